/* design/rmts_pkg.sv */
// Package for the rate monotonic tick scheduler.
// Shared types and configuration register indexes; no dependencies.
package rmts_pkg;

  localparam int TIME_W   = 32;
  localparam int WORK_W   = 16;
  localparam int ID_W     = 8;
  localparam int SLOT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int COUNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLOT0 = 3'd1;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [WORK_W-1:0] work_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WORK_W-1:0] period;
    logic [WORK_W-1:0] budget;
  } slot_cfg_t;

  typedef struct packed {
    logic              busy;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
  } sched_res_t;

endpackage

/* design/rmts_cfg.sv */
// Configuration register file: task count and per-slot descriptors.
// Depends on rmts_pkg.
module rmts_cfg import rmts_pkg::*; #(
  parameter int NUM_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [COUNT_W-1:0]    task_count,
  output slot_cfg_t             slot_cfg [NUM_SLOTS]
);

  logic [COUNT_W-1:0] count_r;
  slot_cfg_t          slot_r [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) slot_r[s] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_COUNT) count_r <= cfg_wdata[COUNT_W-1:0];
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_IDX_SLOT0) + s)) slot_r[s] <= cfg_wdata;
      end
    end
  end

  assign task_count = count_r;
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) slot_cfg[s] = slot_r[s];
  end

endmodule

/* design/rmts_sched.sv */
// One-tick scheduling step: release check, priority pick, budget decrement.
// Purely combinational; depends on rmts_pkg.
module rmts_sched import rmts_pkg::*; #(
  parameter int NUM_SLOTS = 4
) (
  input  logic               restart,
  input  logic [COUNT_W-1:0] task_count,
  input  slot_cfg_t          slot_cfg  [NUM_SLOTS],
  input  time_t              time_now,
  input  time_t              rel_at    [NUM_SLOTS],
  input  work_t              work_left [NUM_SLOTS],
  output time_t              tick_time,
  output time_t              time_nxt,
  output time_t              rel_nxt   [NUM_SLOTS],
  output work_t              work_nxt  [NUM_SLOTS],
  output sched_res_t         res
);

  logic [NUM_SLOTS-1:0] act;
  work_t                work_rel [NUM_SLOTS];
  logic                 found;
  logic [SLOT_W-1:0]    pick;
  work_t                best;
  logic [ID_W-1:0]      pick_id;
  time_t                rel_cur;

  assign tick_time = restart ? '0 : time_now;
  assign time_nxt  = tick_time + 1'b1;

  // release: a slot whose release time matches reloads its budget
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      act[s]      = task_count > COUNT_W'(s);
      rel_cur     = restart ? '0 : rel_at[s];
      work_rel[s] = restart ? '0 : work_left[s];
      rel_nxt[s]  = rel_cur;
      if (act[s] && rel_cur == tick_time) begin
        work_rel[s] = slot_cfg[s].budget;
        rel_nxt[s]  = rel_cur + TIME_W'(slot_cfg[s].period);
      end
    end
  end

  // shortest period wins, strict compare keeps the lower slot on ties
  always_comb begin
    found   = 1'b0;
    pick    = '0;
    best    = '0;
    pick_id = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (act[s] && work_rel[s] != '0 && (!found || slot_cfg[s].period < best)) begin
        found   = 1'b1;
        pick    = SLOT_W'(s);
        best    = slot_cfg[s].period;
        pick_id = slot_cfg[s].id;
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      work_nxt[s] = (found && pick == SLOT_W'(s)) ? work_rel[s] - 1'b1 : work_rel[s];
    end
  end

  assign res.busy = found;
  assign res.id   = pick_id;
  assign res.slot = pick;

endmodule

/* design/rate_monotonic_tick_scheduler_core.sv */
// Top level of the rate monotonic tick scheduler: input stage, state, result stage.
// Depends on rmts_pkg, rmts_cfg and rmts_sched.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid / in_ready    | in_restart
//  out     | output    | out_valid / out_ready  | out_tick_time, out_busy_res,
//          |           |                        | out_running_id, out_running_slot
//  cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One tick per cycle sustained while out_ready holds; a taken beat passes the
// input register, then the result register. The scheduler state feeds back
// through the release compare and the four-way priority pick.
// rst_n is synchronous: clears config, time, release times and remaining work.
// A stalled output holds the result stage; the input stage still takes one beat
// while the result waits, then in_ready drops until out_ready returns.
module rate_monotonic_tick_scheduler_core import rmts_pkg::*; #(
  parameter int NUM_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TIME_W-1:0]     out_tick_time,
  output logic                  out_busy_res,
  output logic [ID_W-1:0]       out_running_id,
  output logic [SLOT_W-1:0]     out_running_slot,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [COUNT_W-1:0] task_count;
  slot_cfg_t          slot_cfg [NUM_SLOTS];

  // input stage
  logic s1_valid_r, s1_restart_r;
  // scheduler state
  time_t time_r;
  time_t rel_r  [NUM_SLOTS];
  work_t work_r [NUM_SLOTS];
  // result stage
  logic       out_valid_r;
  time_t      tick_r;
  sched_res_t res_r;

  time_t      tick_time, time_nxt;
  time_t      rel_nxt  [NUM_SLOTS];
  work_t      work_nxt [NUM_SLOTS];
  sched_res_t res;
  logic       advance;

  rmts_cfg #(.NUM_SLOTS(NUM_SLOTS)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .task_count (task_count),
    .slot_cfg   (slot_cfg)
  );

  rmts_sched #(.NUM_SLOTS(NUM_SLOTS)) u_sched (
    .restart    (s1_restart_r),
    .task_count (task_count),
    .slot_cfg   (slot_cfg),
    .time_now   (time_r),
    .rel_at     (rel_r),
    .work_left  (work_r),
    .tick_time  (tick_time),
    .time_nxt   (time_nxt),
    .rel_nxt    (rel_nxt),
    .work_nxt   (work_nxt),
    .res        (res)
  );

  // result stage moves when empty or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s1_restart_r <= in_restart;
  end

  // state commits exactly when a tick leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        rel_r[s]  <= '0;
        work_r[s] <= '0;
      end
    end else if (advance && s1_valid_r) begin
      time_r <= time_nxt;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        rel_r[s]  <= rel_nxt[s];
        work_r[s] <= work_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      tick_r <= tick_time;
      res_r  <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tick_time    = tick_r;
  assign out_busy_res     = res_r.busy;
  assign out_running_id   = res_r.id;
  assign out_running_slot = res_r.slot;

endmodule

/* design/rmts_checker.sv */
// Port-level checks for the rate monotonic tick scheduler, bound to the top level.
// Depends on rmts_pkg and rate_monotonic_tick_scheduler_core.
module rmts_checker import rmts_pkg::*; #(
  parameter int NUM_SLOTS = 4
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [TIME_W-1:0]     out_tick_time,
  input logic                  out_busy_res,
  input logic [ID_W-1:0]       out_running_id,
  input logic [SLOT_W-1:0]     out_running_slot
);

  // beats taken but not yet delivered
  logic [1:0] pend_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_time) &&
      $stable(out_busy_res) && $stable(out_running_id) && $stable(out_running_slot))
    else $error("result beat changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_running_id == '0 && out_running_slot == '0)
    else $error("idle tick reports a task");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_res |-> 32'(out_running_slot) < NUM_SLOTS)
    else $error("running slot beyond configured slots");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted tick");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_ready || out_beat)
    else $error("more than two ticks in flight");

endmodule

bind rate_monotonic_tick_scheduler_core rmts_checker #(.NUM_SLOTS(NUM_SLOTS)) u_rmts_checker (.*);
